// ===== src/vertex_normal_accumulator_core_defines.svh =====
// assertion macros used by the core's checks
`ifndef VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define VNA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vna assertion failed");

// next-cycle implication
`define VNA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vna assertion failed");

`endif

// ===== src/vna_pkg.sv =====
package vna_pkg;

  localparam int IDX_W     = 10;
  localparam int FIELD_W   = 16;
  localparam int OUT_W     = 16;
  localparam int ACT_W     = 2;
  localparam int FRAC_BITS = 14;
  localparam int CORNERS   = 3;
  localparam logic [2:0] MUL_STEPS = 3'd6;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TRI   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PA, ST_PB, ST_PC, ST_PW, ST_MUL,
    ST_ARD, ST_AWR, ST_NRD, ST_NGO, ST_NWAIT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_SQL, N_ROOT, N_DIV, N_FIN
  } norm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_stat_t;

endpackage

// ===== src/vna_ifs.sv =====
interface vna_in_if;
  logic                             valid;
  logic                             ready;
  logic [vna_pkg::ACT_W-1:0]        action;
  logic [vna_pkg::IDX_W-1:0]        vertex_index;
  logic [vna_pkg::IDX_W-1:0]        corner_b;
  logic [vna_pkg::IDX_W-1:0]        corner_c;
  logic signed [vna_pkg::FIELD_W-1:0] coord_x;
  logic signed [vna_pkg::FIELD_W-1:0] coord_y;
  logic signed [vna_pkg::FIELD_W-1:0] coord_z;

  modport source (output valid, action, vertex_index, corner_b, corner_c,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, action, vertex_index, corner_b, corner_c,
                coord_x, coord_y, coord_z, output ready);
endinterface

interface vna_out_if;
  logic                             valid;
  logic                             ready;
  logic [vna_pkg::IDX_W-1:0]        read_index;
  logic signed [vna_pkg::OUT_W-1:0] normal_x;
  logic signed [vna_pkg::OUT_W-1:0] normal_y;
  logic signed [vna_pkg::OUT_W-1:0] normal_z;
  logic                             zero_length;

  modport source (output valid, read_index, normal_x, normal_y, normal_z,
                  zero_length, input ready);
  modport sink (input valid, read_index, normal_x, normal_y, normal_z,
                zero_length, output ready);
endinterface

// ===== src/vna_ram.sv =====
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/vna_norm.sv =====
module vna_norm #(
  parameter int SUM_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [3*SUM_BITS-1:0]             sums,
  output logic [3*vna_pkg::OUT_W-1:0]       nrm,
  output logic                              zero_len,
  output vna_pkg::norm_stat_t               stat
);

  localparam int SW   = SUM_BITS;
  localparam int H    = (SW + 1) / 2;
  localparam int MW   = 2 * H;
  localparam int QW   = 2 * MW + 2;
  localparam int RW   = MW + 1;
  localparam int REMW = RW + 3;
  localparam int DVW  = RW + 1;
  localparam int QBW  = vna_pkg::FRAC_BITS + 1;
  localparam int RCW  = $clog2(RW);
  localparam int DCW  = $clog2(QBW);
  localparam int OW   = vna_pkg::OUT_W;

  vna_pkg::norm_state_t state_r, state_nxt;

  logic [MW-1:0]   m_r [3];
  logic            neg_r [3];
  logic            zero_r;
  logic [1:0]      ci_r, pi_r, pd_r;
  logic            pv_r;
  logic [2*H-1:0]  prod_r;
  logic [QW-1:0]   sq_r;
  logic [REMW-1:0] rem_r;
  logic [RW-1:0]   root_r;
  logic [RCW-1:0]  rcnt_r;
  logic [DVW-1:0]  dr_r [3];
  logic [QBW-1:0]  q_r [3];
  logic [DCW-1:0]  dcnt_r;
  logic [OW-1:0]   nrm_r [3];

  logic [MW-1:0]   mag_c [3];
  logic [MW-1:0]   msel;
  logic [H-1:0]    op_a, op_b;
  logic [QW-1:0]   part_c;
  logic [REMW-1:0] rem_t, trial;
  logic            root_ge;
  logic [DVW-1:0]  dsh [3], dnext [3];
  logic            dge [3];
  logic            last_sq;

  // magnitudes of the incoming sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = sums[i*SW + SW - 1] ? MW'(~sums[i*SW +: SW] + SW'(1))
                                     : MW'(sums[i*SW +: SW]);
    end
  end

  // one half-by-half partial product per cycle
  assign msel = m_r[ci_r];
  always_comb begin
    unique case (pi_r)
      2'd0:    begin op_a = msel[H-1:0];  op_b = msel[H-1:0]; end
      2'd1:    begin op_a = msel[MW-1:H]; op_b = msel[H-1:0]; end
      2'd2:    begin op_a = msel[MW-1:H]; op_b = msel[MW-1:H]; end
      default: begin op_a = '0;           op_b = '0; end
    endcase
  end

  always_comb begin
    unique case (pd_r)
      2'd0:    part_c = QW'(prod_r);
      2'd1:    part_c = QW'(prod_r) << (H + 1);
      2'd2:    part_c = QW'(prod_r) << (2 * H);
      default: part_c = '0;
    endcase
  end

  assign last_sq = (ci_r == 2'd2) && (pi_r == 2'd2);

  // digit-by-digit square root, two radicand bits per step
  assign rem_t   = {rem_r[REMW-3:0], sq_r[QW-1 -: 2]};
  assign trial   = REMW'({root_r, 2'b01});
  assign root_ge = rem_t >= trial;

  // restoring division, one quotient bit per step in each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsh[i]   = (dcnt_r == '0) ? dr_r[i] : {dr_r[i][DVW-2:0], 1'b0};
      dge[i]   = dsh[i] >= DVW'(root_r);
      dnext[i] = dge[i] ? dsh[i] - DVW'(root_r) : dsh[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::N_IDLE: begin
        if (start) begin
          state_nxt = (sums == '0) ? vna_pkg::N_FIN : vna_pkg::N_SQ;
        end
      end
      vna_pkg::N_SQ:   if (last_sq) state_nxt = vna_pkg::N_SQL;
      vna_pkg::N_SQL:  state_nxt = vna_pkg::N_ROOT;
      vna_pkg::N_ROOT: if (rcnt_r == RCW'(RW - 1)) state_nxt = vna_pkg::N_DIV;
      vna_pkg::N_DIV:  if (dcnt_r == DCW'(QBW - 1)) state_nxt = vna_pkg::N_FIN;
      vna_pkg::N_FIN:  state_nxt = vna_pkg::N_IDLE;
      default:         state_nxt = vna_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = state_r != vna_pkg::N_IDLE;
    stat.done = state_r == vna_pkg::N_FIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::N_IDLE;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= state_r == vna_pkg::N_SQ;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    pd_r   <= pi_r;
    if (pv_r) begin
      sq_r <= sq_r + part_c;
    end
    unique case (state_r)
      vna_pkg::N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          m_r[i]   <= mag_c[i];
          neg_r[i] <= sums[i*SW + SW - 1];
        end
        zero_r <= sums == '0;
        ci_r   <= 2'd0;
        pi_r   <= 2'd0;
        sq_r   <= '0;
        rem_r  <= '0;
        root_r <= '0;
        rcnt_r <= '0;
      end
      vna_pkg::N_SQ: begin
        if (pi_r == 2'd2) begin
          pi_r <= 2'd0;
          ci_r <= ci_r + 2'd1;
        end else begin
          pi_r <= pi_r + 2'd1;
        end
      end
      vna_pkg::N_SQL: ;
      vna_pkg::N_ROOT: begin
        sq_r   <= {sq_r[QW-3:0], 2'b00};
        rem_r  <= root_ge ? rem_t - trial : rem_t;
        root_r <= {root_r[RW-2:0], root_ge};
        rcnt_r <= rcnt_r + RCW'(1);
        dcnt_r <= '0;
        for (int i = 0; i < 3; i++) begin
          dr_r[i] <= DVW'(m_r[i]);
          q_r[i]  <= '0;
        end
      end
      vna_pkg::N_DIV: begin
        dcnt_r <= dcnt_r + DCW'(1);
        for (int i = 0; i < 3; i++) begin
          dr_r[i] <= dnext[i];
          q_r[i]  <= {q_r[i][QBW-2:0], dge[i]};
        end
      end
      vna_pkg::N_FIN: begin
        for (int i = 0; i < 3; i++) begin
          if (zero_r) begin
            nrm_r[i] <= '0;
          end else if (neg_r[i]) begin
            nrm_r[i] <= OW'(0) - OW'(q_r[i]);
          end else begin
            nrm_r[i] <= OW'(q_r[i]);
          end
        end
        zero_len <= zero_r;
      end
      default: ;
    endcase
  end

  assign nrm = {nrm_r[2], nrm_r[1], nrm_r[0]};

endmodule

// ===== src/vertex_normal_accumulator_core.sv =====
// load and clear complete in the idle state; add triangle runs the multiply and
// accumulate states; read normal waits on the bit-serial square root
// throughput: one item at a time; the next item is taken once the current one
// has finished; a read result waits in the output register, holding up only a later read
// reset: synchronous active-low; afterwards a clearing pass zeroes the
// accumulator memory, with no input taken during it
`include "vertex_normal_accumulator_core_defines.svh"

module vertex_normal_accumulator_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch
);

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;           // coordinate difference
  localparam int PW   = 2 * DW;           // one cross-product term
  localparam int NW   = PW + 1;           // face normal component
  localparam int SW   = SUM_BITS;
  localparam int AW   = (SW > NW ? SW : NW) + 1;
  localparam int XW   = (CW > vna_pkg::FIELD_W ? CW : vna_pkg::FIELD_W);
  localparam int CMPW = (IW > vna_pkg::IDX_W ? IW : vna_pkg::IDX_W) + 1;
  localparam int OW   = vna_pkg::OUT_W;
  localparam logic [CMPW-1:0] NV = CMPW'(MAX_VERTICES);
  localparam logic signed [AW-1:0] SMAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  vna_pkg::state_t  state_r, state_nxt;
  vna_pkg::action_t act;

  logic [IW-1:0] clr_r, a_r, b_r, c_r, corner;
  logic [1:0]    j_r;
  logic [2:0]    k_r, pk_r;
  logic          pv_r;
  logic          oor_r;
  logic [vna_pkg::IDX_W-1:0] ri_r;

  // handshake and index checks
  logic in_acc, a_ok, b_ok, c_ok;
  logic [IW-1:0] in_a, in_b, in_c;

  // position memory
  logic            pos_we;
  logic [IW-1:0]   pos_raddr;
  logic [3*CW-1:0] pos_wdata, pos_rdata, pa_r, pb_r;
  logic [XW-1:0]   zx, zy, zz;
  logic signed [CW-1:0] pa_c [3], pb_c [3], pc_c [3];

  // cross product
  logic signed [DW-1:0] u_r [3], v_r [3];
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_r;
  logic signed [NW-1:0] n_r [3];
  logic signed [NW-1:0] prod_ext;

  // accumulator memory
  logic            acc_we;
  logic [IW-1:0]   acc_waddr, acc_raddr;
  logic [3*SW-1:0] acc_wdata, acc_rdata, sat_word;
  logic signed [AW-1:0] sum_w [3];

  // normalizer
  logic                 norm_start;
  logic [3*OW-1:0]      norm_nrm;
  logic                 norm_zero;
  vna_pkg::norm_stat_t  norm_stat;

  // output word register
  logic                 out_load;
  logic                 out_valid_r;
  logic [vna_pkg::IDX_W-1:0] out_idx_r;
  logic [OW-1:0]        out_x_r, out_y_r, out_z_r;
  logic                 out_zero_r;

  assign act    = vna_pkg::action_t'(in_ch.action);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign a_ok   = CMPW'(in_ch.vertex_index) < NV;
  assign b_ok   = CMPW'(in_ch.corner_b) < NV;
  assign c_ok   = CMPW'(in_ch.corner_c) < NV;
  assign in_a   = IW'(in_ch.vertex_index);
  assign in_b   = IW'(in_ch.corner_b);
  assign in_c   = IW'(in_ch.corner_c);

  // only the low COORD_BITS bits of a coordinate are kept
  assign zx = XW'($unsigned(in_ch.coord_x));
  assign zy = XW'($unsigned(in_ch.coord_y));
  assign zz = XW'($unsigned(in_ch.coord_z));
  assign pos_wdata = {zz[CW-1:0], zy[CW-1:0], zx[CW-1:0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = $signed(pa_r[i*CW +: CW]);
      pb_c[i] = $signed(pb_r[i*CW +: CW]);
      pc_c[i] = $signed(pos_rdata[i*CW +: CW]);
    end
  end

  // corner currently being updated
  always_comb begin
    unique case (j_r)
      2'd0:    corner = a_r;
      2'd1:    corner = b_r;
      default: corner = c_r;
    endcase
  end

  vna_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_VERTICES)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (in_a),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(
    .WIDTH (3 * SW),
    .DEPTH (MAX_VERTICES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  vna_norm #(
    .SUM_BITS (SUM_BITS)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (norm_start),
    .sums     (acc_rdata),
    .nrm      (norm_nrm),
    .zero_len (norm_zero),
    .stat     (norm_stat)
  );

  // cross-product term order: x = uy*vz - uz*vy, y = uz*vx - ux*vz,
  // z = ux*vy - uy*vx
  always_comb begin
    unique case (k_r)
      3'd0:    begin op_a = u_r[1]; op_b = v_r[2]; end
      3'd1:    begin op_a = u_r[2]; op_b = v_r[1]; end
      3'd2:    begin op_a = u_r[2]; op_b = v_r[0]; end
      3'd3:    begin op_a = u_r[0]; op_b = v_r[2]; end
      3'd4:    begin op_a = u_r[0]; op_b = v_r[1]; end
      3'd5:    begin op_a = u_r[1]; op_b = v_r[0]; end
      default: begin op_a = '0;     op_b = '0; end
    endcase
  end

  assign prod_ext = NW'(prod_r);

  // saturating add of the face normal into the fetched sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = AW'($signed(acc_rdata[i*SW +: SW])) + AW'(n_r[i]);
      if (sum_w[i] > SMAX) begin
        sat_word[i*SW +: SW] = SMAX[SW-1:0];
      end else if (sum_w[i] < SMIN) begin
        sat_word[i*SW +: SW] = SMIN[SW-1:0];
      end else begin
        sat_word[i*SW +: SW] = sum_w[i][SW-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::ST_INIT: begin
        if (clr_r == IW'(MAX_VERTICES - 1)) state_nxt = vna_pkg::ST_IDLE;
      end
      vna_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (act)
            vna_pkg::ACT_LOAD:  state_nxt = vna_pkg::ST_IDLE;
            vna_pkg::ACT_CLEAR: state_nxt = vna_pkg::ST_IDLE;
            vna_pkg::ACT_TRI: begin
              state_nxt = (a_ok && b_ok && c_ok) ? vna_pkg::ST_PA : vna_pkg::ST_IDLE;
            end
            vna_pkg::ACT_READ: begin
              state_nxt = a_ok ? vna_pkg::ST_NRD : vna_pkg::ST_OUT;
            end
            default: state_nxt = vna_pkg::ST_IDLE;
          endcase
        end
      end
      vna_pkg::ST_PA:  state_nxt = vna_pkg::ST_PB;
      vna_pkg::ST_PB:  state_nxt = vna_pkg::ST_PC;
      vna_pkg::ST_PC:  state_nxt = vna_pkg::ST_PW;
      vna_pkg::ST_PW:  state_nxt = vna_pkg::ST_MUL;
      vna_pkg::ST_MUL: if (k_r == vna_pkg::MUL_STEPS) state_nxt = vna_pkg::ST_ARD;
      vna_pkg::ST_ARD: state_nxt = vna_pkg::ST_AWR;
      vna_pkg::ST_AWR: begin
        state_nxt = (j_r == 2'(vna_pkg::CORNERS - 1)) ? vna_pkg::ST_IDLE
                                                      : vna_pkg::ST_ARD;
      end
      vna_pkg::ST_NRD:   state_nxt = vna_pkg::ST_NGO;
      vna_pkg::ST_NGO:   state_nxt = vna_pkg::ST_NWAIT;
      vna_pkg::ST_NWAIT: if (norm_stat.done) state_nxt = vna_pkg::ST_OUT;
      vna_pkg::ST_OUT:   if (out_load) state_nxt = vna_pkg::ST_IDLE;
      default:           state_nxt = vna_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = state_r == vna_pkg::ST_IDLE;
    pos_we      = 1'b0;
    acc_we      = 1'b0;
    acc_waddr   = a_r;
    acc_wdata   = '0;
    norm_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      vna_pkg::ST_PA:  pos_raddr = a_r;
      vna_pkg::ST_PB:  pos_raddr = b_r;
      default:         pos_raddr = c_r;
    endcase
    acc_raddr = (state_r == vna_pkg::ST_ARD) ? corner : a_r;
    unique case (state_r)
      vna_pkg::ST_INIT: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
      end
      vna_pkg::ST_IDLE: begin
        pos_we    = in_acc && (act == vna_pkg::ACT_LOAD) && a_ok;
        acc_we    = in_acc && (act == vna_pkg::ACT_CLEAR) && a_ok;
        acc_waddr = in_a;
      end
      vna_pkg::ST_AWR: begin
        acc_we    = 1'b1;
        acc_waddr = corner;
        acc_wdata = sat_word;
      end
      vna_pkg::ST_NGO: norm_start = 1'b1;
      vna_pkg::ST_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == vna_pkg::ST_INIT) begin
        clr_r <= clr_r + IW'(1);
      end
      pv_r <= (state_r == vna_pkg::ST_MUL) && (k_r != vna_pkg::MUL_STEPS);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r   <= in_a;
      b_r   <= in_b;
      c_r   <= in_c;
      ri_r  <= in_ch.vertex_index;
      oor_r <= !a_ok;
      k_r   <= '0;
      j_r   <= '0;
    end
    if (state_r == vna_pkg::ST_PB) pa_r <= pos_rdata;
    if (state_r == vna_pkg::ST_PC) pb_r <= pos_rdata;
    if (state_r == vna_pkg::ST_PW) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= DW'(pb_c[i]) - DW'(pa_c[i]);
        v_r[i] <= DW'(pc_c[i]) - DW'(pa_c[i]);
      end
    end
    if (state_r == vna_pkg::ST_MUL) k_r <= k_r + 3'd1;
    prod_r <= op_a * op_b;
    pk_r   <= k_r;
    if (pv_r) begin
      unique case (pk_r)
        3'd0:    n_r[0] <= prod_ext;
        3'd1:    n_r[0] <= n_r[0] - prod_ext;
        3'd2:    n_r[1] <= prod_ext;
        3'd3:    n_r[1] <= n_r[1] - prod_ext;
        3'd4:    n_r[2] <= prod_ext;
        3'd5:    n_r[2] <= n_r[2] - prod_ext;
        default: ;
      endcase
    end
    if (state_r == vna_pkg::ST_AWR) j_r <= j_r + 2'd1;
    if (out_load) begin
      out_idx_r <= ri_r;
      if (oor_r) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_z_r    <= '0;
        out_zero_r <= 1'b1;
      end else begin
        out_x_r    <= norm_nrm[0 +: OW];
        out_y_r    <= norm_nrm[OW +: OW];
        out_z_r    <= norm_nrm[2*OW +: OW];
        out_zero_r <= norm_zero;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_index  = out_idx_r;
  assign out_ch.normal_x    = out_x_r;
  assign out_ch.normal_y    = out_y_r;
  assign out_ch.normal_z    = out_z_r;
  assign out_ch.zero_length = out_zero_r;

  // checks
  `VNA_ASSERT_IMPL(a_norm_start_idle, clk, rst_n, norm_start, !norm_stat.busy)
  `VNA_ASSERT_IMPL(a_out_no_overwrite, clk, rst_n, out_load, !out_valid_r || out_ch.ready)
  `VNA_ASSERT_NEXT(a_read_fetch, clk, rst_n, in_acc && act == vna_pkg::ACT_READ && a_ok, state_r == vna_pkg::ST_NRD)

endmodule

// ===== tb/sv/vertex_normal_accumulator_core_tb.sv =====
module vertex_normal_accumulator_core_tb;

  localparam int NVERT   = 1024;
  localparam int SUM_W   = 48;
  localparam int N_RAND  = 650;
  localparam int POOL    = 24;   // small vertex pool so triangles share corners
  localparam int N_DIR   = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vna_in_if  in_ch();
  vna_out_if out_ch();

  vertex_normal_accumulator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected read result
  typedef struct {
    logic [vna_pkg::IDX_W-1:0]        read_index;
    logic signed [vna_pkg::OUT_W-1:0] normal_x;
    logic signed [vna_pkg::OUT_W-1:0] normal_y;
    logic signed [vna_pkg::OUT_W-1:0] normal_z;
    logic                             zero_length;
  } normal_word_t;

  // one input word
  typedef struct {
    vna_pkg::action_t          act;
    logic [vna_pkg::IDX_W-1:0] idx;
    logic [vna_pkg::IDX_W-1:0] cb;
    logic [vna_pkg::IDX_W-1:0] cc;
    logic signed [15:0]        px;
    logic signed [15:0]        py;
    logic signed [15:0]        pz;
  } mesh_word_t;

  // shadow copy of block state
  logic signed [15:0]      pos_x [NVERT];
  logic signed [15:0]      pos_y [NVERT];
  logic signed [15:0]      pos_z [NVERT];
  logic signed [SUM_W-1:0] acc_x [NVERT];
  logic signed [SUM_W-1:0] acc_y [NVERT];
  logic signed [SUM_W-1:0] acc_z [NVERT];

  normal_word_t pending_normals[$];
  int  fail_count = 0;
  int  tbl_fail = 0;
  int  src_idle_pct = 8;
  int  snk_idle_pct = 73;

  // saturating add into a 48-bit sum
  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] a,
                                                      logic signed [63:0] v);
    logic signed [63:0] wide;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi   = (64'sd1 <<< (SUM_W - 1)) - 1;
    lo   = -hi - 1;
    wide = 64'(a) + v;
    if (wide > hi) return hi[SUM_W-1:0];
    if (wide < lo) return lo[SUM_W-1:0];
    return wide[SUM_W-1:0];
  endfunction

  // floor sqrt of a 128-bit square
  function automatic logic [63:0] root_of(logic [127:0] sq);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= sq) r = c;
    end
    return r;
  endfunction

  // trunc(2^14 * s / len), sign kept
  function automatic logic signed [vna_pkg::OUT_W-1:0] unit_component(
      logic signed [SUM_W-1:0] s, logic [63:0] len);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (s < 0) ? 128'(-64'(s)) : 128'(s);
    q   = (mag << vna_pkg::FRAC_BITS) / {64'd0, len};
    return (s < 0) ? -q[vna_pkg::OUT_W-1:0] : q[vna_pkg::OUT_W-1:0];
  endfunction

  // apply one word to the shadow state, queue any read result
  task automatic mesh_apply(mesh_word_t w);
    logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] sq;
    logic [63:0]  len;
    logic [63:0]  m;
    normal_word_t e;
    int           vi [3];
    case (w.act)
      vna_pkg::ACT_LOAD: begin
        pos_x[w.idx] = w.px; pos_y[w.idx] = w.py; pos_z[w.idx] = w.pz;
      end
      vna_pkg::ACT_CLEAR: begin
        acc_x[w.idx] = '0; acc_y[w.idx] = '0; acc_z[w.idx] = '0;
      end
      vna_pkg::ACT_TRI: begin
        ux = 64'(pos_x[w.cb]) - 64'(pos_x[w.idx]);
        uy = 64'(pos_y[w.cb]) - 64'(pos_y[w.idx]);
        uz = 64'(pos_z[w.cb]) - 64'(pos_z[w.idx]);
        vx = 64'(pos_x[w.cc]) - 64'(pos_x[w.idx]);
        vy = 64'(pos_y[w.cc]) - 64'(pos_y[w.idx]);
        vz = 64'(pos_z[w.cc]) - 64'(pos_z[w.idx]);
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        vi[0] = w.idx; vi[1] = w.cb; vi[2] = w.cc;
        foreach (vi[k]) begin
          acc_x[vi[k]] = sat_sum(acc_x[vi[k]], nx);
          acc_y[vi[k]] = sat_sum(acc_y[vi[k]], ny);
          acc_z[vi[k]] = sat_sum(acc_z[vi[k]], nz);
        end
      end
      default: begin
        e = '{w.idx, '0, '0, '0, 1'b1};
        sq = '0;
        m = (acc_x[w.idx] < 0) ? -64'(acc_x[w.idx]) : 64'(acc_x[w.idx]);
        sq += {64'd0, m} * {64'd0, m};
        m = (acc_y[w.idx] < 0) ? -64'(acc_y[w.idx]) : 64'(acc_y[w.idx]);
        sq += {64'd0, m} * {64'd0, m};
        m = (acc_z[w.idx] < 0) ? -64'(acc_z[w.idx]) : 64'(acc_z[w.idx]);
        sq += {64'd0, m} * {64'd0, m};
        if (sq != 0) begin
          len = root_of(sq);
          e.normal_x = unit_component(acc_x[w.idx], len);
          e.normal_y = unit_component(acc_y[w.idx], len);
          e.normal_z = unit_component(acc_z[w.idx], len);
          e.zero_length = 1'b0;
        end
        pending_normals.push_back(e);
      end
    endcase
  endtask

  // drive one word, wait until the block takes it
  task automatic send_word(mesh_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= w.act;
    in_ch.vertex_index <= w.idx;
    in_ch.corner_b     <= w.cb;
    in_ch.corner_c     <= w.cc;
    in_ch.coord_x      <= w.px;
    in_ch.coord_y      <= w.py;
    in_ch.coord_z      <= w.pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    mesh_apply(w);
  endtask

  // typed-in values must agree with the shadow prediction
  task automatic check_row(int row, normal_word_t got, normal_word_t want);
    if (got.read_index !== want.read_index) begin
      $error("row %0d read_index exp %0d got %0d", row, want.read_index, got.read_index);
      tbl_fail++;
    end
    if (got.normal_x !== want.normal_x) begin
      $error("row %0d normal_x exp %0d got %0d", row, want.normal_x, got.normal_x);
      tbl_fail++;
    end
    if (got.normal_y !== want.normal_y) begin
      $error("row %0d normal_y exp %0d got %0d", row, want.normal_y, got.normal_y);
      tbl_fail++;
    end
    if (got.normal_z !== want.normal_z) begin
      $error("row %0d normal_z exp %0d got %0d", row, want.normal_z, got.normal_z);
      tbl_fail++;
    end
    if (got.zero_length !== want.zero_length) begin
      $error("row %0d zero_length exp %0d got %0d", row, want.zero_length,
             got.zero_length);
      tbl_fail++;
    end
  endtask

  // receiver: random stalls and field checks
  always @(posedge clk) begin
    normal_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_normals.size() == 0) begin
          $error("unexpected normal word for vertex %0d", out_ch.read_index);
          fail_count++;
        end else begin
          e = pending_normals.pop_front();
          if (out_ch.read_index !== e.read_index) begin
            $error("read_index exp %0d got %0d", e.read_index, out_ch.read_index);
            fail_count++;
          end
          if (out_ch.normal_x !== e.normal_x) begin
            $error("normal_x exp %0d got %0d", e.normal_x, out_ch.normal_x);
            fail_count++;
          end
          if (out_ch.normal_y !== e.normal_y) begin
            $error("normal_y exp %0d got %0d", e.normal_y, out_ch.normal_y);
            fail_count++;
          end
          if (out_ch.normal_z !== e.normal_z) begin
            $error("normal_z exp %0d got %0d", e.normal_z, out_ch.normal_z);
            fail_count++;
          end
          if (out_ch.zero_length !== e.zero_length) begin
            $error("zero_length exp %0d got %0d", e.zero_length, out_ch.zero_length);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // random vertex among the loaded ones in the pool
  function automatic logic [vna_pkg::IDX_W-1:0] pick_vertex(int base);
    return vna_pkg::IDX_W'(base + $urandom_range(POOL - 1));
  endfunction

  function automatic mesh_word_t rand_word(int base);
    mesh_word_t w;
    int r;
    r = $urandom_range(99);
    w.px = 16'($urandom); w.py = 16'($urandom); w.pz = 16'($urandom);
    w.cb = vna_pkg::IDX_W'($urandom);
    w.cc = vna_pkg::IDX_W'($urandom);
    w.idx = vna_pkg::IDX_W'($urandom);
    if (r < 15) begin
      w.act = vna_pkg::ACT_LOAD;
      w.idx = pick_vertex(base);
      // mostly modest coordinates so normals stay unsaturated
      if ($urandom_range(3) != 0) begin
        w.px = $signed(16'($urandom_range(2047))) - 16'sd1024;
        w.py = $signed(16'($urandom_range(2047))) - 16'sd1024;
        w.pz = $signed(16'($urandom_range(2047))) - 16'sd1024;
      end
    end else if (r < 60) begin
      w.act = vna_pkg::ACT_TRI;
      w.idx = pick_vertex(base); w.cb = pick_vertex(base); w.cc = pick_vertex(base);
    end else if (r < 90) begin
      w.act = vna_pkg::ACT_READ;
      if ($urandom_range(9) != 0) w.idx = pick_vertex(base);
    end else begin
      w.act = vna_pkg::ACT_CLEAR;
      if ($urandom_range(1) == 0) w.idx = pick_vertex(base);
    end
    return w;
  endfunction

  mesh_word_t   dir_rows [N_DIR];
  normal_word_t dir_exp  [N_DIR];
  bit           dir_has  [N_DIR];

  initial begin
    mesh_word_t w;
    int base;
    in_ch.valid = 1'b0;
    in_ch.action = vna_pkg::ACT_LOAD;
    in_ch.vertex_index = '0; in_ch.corner_b = '0; in_ch.corner_c = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    for (int i = 0; i < NVERT; i++) begin
      pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0;
      acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0;
    end
    foreach (dir_has[i]) dir_has[i] = 1'b0;

    // directed table; expected word typed only where obvious
    dir_rows[0]  = '{vna_pkg::ACT_READ,  10'd0,    '0, '0, '0, '0, '0};   // right after reset
    dir_has[0] = 1; dir_exp[0] = '{10'd0, '0, '0, '0, 1'b1};
    dir_rows[1]  = '{vna_pkg::ACT_READ,  10'd1023, '0, '0, '0, '0, '0};
    dir_has[1] = 1; dir_exp[1] = '{10'd1023, '0, '0, '0, 1'b1};
    dir_rows[2]  = '{vna_pkg::ACT_LOAD,  10'd0,    '0, '0, 16'sh8000, 16'sh8000, 16'sh8000};
    dir_rows[3]  = '{vna_pkg::ACT_LOAD,  10'd1,    '0, '0, 16'sh7fff, 16'sh8000, 16'sh8000};
    dir_rows[4]  = '{vna_pkg::ACT_LOAD,  10'd2,    '0, '0, 16'sh8000, 16'sh7fff, 16'sh8000};
    dir_rows[5]  = '{vna_pkg::ACT_LOAD,  10'd1023, '0, '0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    // right-angle face in xy plane: normal +z
    dir_rows[6]  = '{vna_pkg::ACT_TRI,   10'd0, 10'd1, 10'd2, '0, '0, '0};
    dir_rows[7]  = '{vna_pkg::ACT_READ,  10'd0, '0, '0, '0, '0, '0};
    dir_has[7] = 1; dir_exp[7] = '{10'd0, '0, '0, 16'sd16384, 1'b0};
    dir_rows[8]  = '{vna_pkg::ACT_TRI,   10'd2, 10'd1, 10'd0, '0, '0, '0};  // reversed winding
    dir_rows[9]  = '{vna_pkg::ACT_READ,  10'd1, '0, '0, '0, '0, '0};
    dir_has[9] = 1; dir_exp[9] = '{10'd1, '0, '0, '0, 1'b1};
    // more full-range faces sharing corners
    dir_rows[10] = '{vna_pkg::ACT_TRI,   10'd0, 10'd1, 10'd2, '0, '0, '0};
    dir_rows[11] = '{vna_pkg::ACT_TRI,   10'd0, 10'd1, 10'd1023, '0, '0, '0};
    dir_rows[12] = '{vna_pkg::ACT_TRI,   10'd1023, 10'd2, 10'd1, '0, '0, '0};
    dir_rows[13] = '{vna_pkg::ACT_READ,  10'd1, '0, '0, '0, '0, '0};
    dir_rows[14] = '{vna_pkg::ACT_READ,  10'd1023, '0, '0, '0, '0, '0};
    // repeated corners: zero face
    dir_rows[15] = '{vna_pkg::ACT_TRI,   10'd2, 10'd2, 10'd2, '0, '0, '0};
    dir_rows[16] = '{vna_pkg::ACT_READ,  10'd2, '0, '0, '0, '0, '0};
    dir_rows[17] = '{vna_pkg::ACT_CLEAR, 10'd0, '0, '0, '0, '0, '0};
    dir_rows[18] = '{vna_pkg::ACT_READ,  10'd0, '0, '0, '0, '0, '0};
    dir_has[18] = 1; dir_exp[18] = '{10'd0, '0, '0, '0, 1'b1};
    dir_rows[19] = '{vna_pkg::ACT_CLEAR, 10'd1023, '0, '0, '0, '0, '0};
    dir_rows[20] = '{vna_pkg::ACT_READ,  10'd1023, '0, '0, '0, '0, '0};
    dir_has[20] = 1; dir_exp[20] = '{10'd1023, '0, '0, '0, 1'b1};
    dir_rows[21] = '{vna_pkg::ACT_LOAD,  10'd3, '0, '0, 16'sh0100, 16'sh0000, 16'sh0000};
    dir_rows[22] = '{vna_pkg::ACT_TRI,   10'd3, 10'd3, 10'd1, '0, '0, '0};
    dir_rows[23] = '{vna_pkg::ACT_READ,  10'd3, '0, '0, '0, '0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, sender and receiver idling at their starting rates
    for (int i = 0; i < N_DIR; i++) begin
      send_word(dir_rows[i]);
      if (dir_has[i]) check_row(i, pending_normals[$], dir_exp[i]);
    end

    // random part in three idling phases, each on its own vertex pool
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin src_idle_pct = 73; snk_idle_pct = 8; end
      if (ph == 2) begin src_idle_pct = 0;  snk_idle_pct = 0; end
      base = 100 + ph * 200;
      for (int v = 0; v < POOL; v++) begin
        w = '{vna_pkg::ACT_LOAD, vna_pkg::IDX_W'(base + v), '0, '0, 16'($urandom),
              16'($urandom), 16'($urandom)};
        if (v % 2 == 0) begin
          w.px = $signed(16'($urandom_range(1023))) - 16'sd512;
          w.py = $signed(16'($urandom_range(1023))) - 16'sd512;
          w.pz = $signed(16'($urandom_range(1023))) - 16'sd512;
        end
        send_word(w);
      end
      for (int n = 0; n < N_RAND / 3 - POOL; n++) send_word(rand_word(base));
    end
    in_ch.valid <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && tbl_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog: clearing pass plus ~700 input words under heavy stalls
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
